[hw/rtl/cmvg_pkg.sv]
`default_nettype none
package cmvg_pkg;

    localparam int MAX_SLICES_DEF = 256;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [33:0] CORDIC_ONE = 34'sd652032874;

    localparam logic [1:0] REG_BOTTOM_RADIUS = 2'd0;
    localparam logic [1:0] REG_TOP_RADIUS    = 2'd1;
    localparam logic [1:0] REG_CYL_HEIGHT    = 2'd2;
    localparam logic [1:0] REG_SLICE_COUNT   = 2'd3;

    localparam logic MODE_VERTEX   = 1'b0;
    localparam logic MODE_TRIANGLE = 1'b1;

    typedef struct packed {
        logic       mode;
        logic       ring;
        logic [8:0] slice;
    } cmvg_in_t;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_z;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic [9:0]         index_a;
        logic [9:0]         index_b;
        logic [9:0]         index_c;
        logic               last;
        logic               range_error;
    } cmvg_out_t;

    function automatic logic signed [33:0] atan_entry(input int k);
        logic signed [33:0] v;
        begin
            unique case (k)
                0: v = 34'sd536870912;
                1: v = 34'sd316933406;
                2: v = 34'sd167458907;
                3: v = 34'sd85004756;
                4: v = 34'sd42667331;
                5: v = 34'sd21354465;
                6: v = 34'sd10679838;
                7: v = 34'sd5340245;
                8: v = 34'sd2670163;
                9: v = 34'sd1335087;
                10: v = 34'sd667544;
                11: v = 34'sd333772;
                12: v = 34'sd166886;
                13: v = 34'sd83443;
                14: v = 34'sd41722;
                15: v = 34'sd20861;
                16: v = 34'sd10430;
                17: v = 34'sd5215;
                18: v = 34'sd2608;
                19: v = 34'sd1304;
                20: v = 34'sd652;
                21: v = 34'sd326;
                22: v = 34'sd163;
                23: v = 34'sd81;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

[hw/rtl/cylinder_mesh_vertex_generator.sv]
`default_nettype none
// Cylinder side-wall mesh generator. Each input item is a vertex query (mode 0) or a
// slice triangle query (mode 1); vertex queries give one result, triangle queries two
// (the second carries last), out-of-range slices one error result. The pipeline takes
// one item per cycle while not stalled. A 33-stage divider forms the 32-bit phase
// i*2^32/n. A CORDIC with CORDIC_STAGES rotation stages plus one quadrant register
// turns it into cos and sin. A multiply stage forms the radius products, and rounding
// and saturation feed the output register directly.
// Triangle items ride the same pipe. A two-entry output buffer holds the second
// triangle of a pair pending behind the first, and no new item is accepted while it
// waits; when the downstream stalls the whole pipe holds. tex_u is the top 17 bits of
// the phase quotient.
module cylinder_mesh_vertex_generator #(
    parameter int MAX_SLICES = cmvg_pkg::MAX_SLICES_DEF,
    parameter int CORDIC_STAGES = cmvg_pkg::CORDIC_STAGES_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  cmvg_pkg::cmvg_in_t  in_data,
    output logic                out_valid,
    input  wire                 out_stall,
    output cmvg_pkg::cmvg_out_t out_data,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire [1:0]           cfg_index,
    input  wire [15:0]          cfg_data
);
    localparam int NW = 9;

    logic [14:0] bottom_radius_reg, top_radius_reg;
    logic [15:0] cyl_height_reg;
    logic [8:0]  slice_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bottom_radius_reg <= 15'd256;
            top_radius_reg    <= 15'd256;
            cyl_height_reg    <= 16'd512;
            slice_count_reg   <= 9'd16;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cmvg_pkg::REG_BOTTOM_RADIUS: bottom_radius_reg <= cfg_data[14:0];
                cmvg_pkg::REG_TOP_RADIUS:    top_radius_reg    <= cfg_data[14:0];
                cmvg_pkg::REG_CYL_HEIGHT:    cyl_height_reg    <= cfg_data;
                default:                     slice_count_reg   <= cfg_data[8:0];
            endcase
        end
    end

    // Effective slice count.
    logic [NW-1:0] n_eff;
    always_comb
    begin
        if (slice_count_reg == '0)
            n_eff = 9'd1;
        else if (32'(slice_count_reg) > MAX_SLICES)
            n_eff = 9'(MAX_SLICES);
        else
            n_eff = slice_count_reg;
    end

    // Sideband: mode, ring, error, slice, n.
    typedef struct packed {
        logic       mode;
        logic       ring;
        logic       err;
        logic [8:0] slice;
        logic [8:0] n;
    } sb_t;
    localparam int SBW = $bits(sb_t);

    logic en;
    logic in_acc;
    sb_t  sb_in;
    assign in_acc = in_valid && !in_stall;
    always_comb
    begin
        sb_in.mode  = in_data.mode;
        sb_in.ring  = in_data.ring;
        sb_in.slice = in_data.slice;
        sb_in.n     = n_eff;
        if (in_data.mode == cmvg_pkg::MODE_VERTEX)
            sb_in.err = in_data.slice > n_eff;
        else
            sb_in.err = in_data.slice >= n_eff;
    end

    logic          dv_valid;
    logic [32:0]   dv_quot;
    logic [SBW-1:0] dv_sb;
    cmvg_divider #(.NW(NW), .SBW(SBW)) u_div (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(in_acc),
        .in_num(in_data.slice),
        .in_den(n_eff),
        .in_sb(sb_in),
        .out_valid(dv_valid), .out_quot(dv_quot), .out_sb(dv_sb)
    );

    // tex_u = floor(i*65536/n) = quotient >> 16; carried with sideband.
    localparam int SB2W = SBW + 17;
    logic               co_valid;
    logic signed [33:0] co_cos, co_sin;
    logic [SB2W-1:0]    co_sb2;
    cmvg_cordic #(.STAGES(CORDIC_STAGES), .SBW(SB2W)) u_cordic (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(dv_valid),
        .in_phase(dv_quot[31:0]),
        .in_sb({dv_sb, dv_quot[32:16]}),
        .out_valid(co_valid), .out_cos(co_cos), .out_sin(co_sin), .out_sb(co_sb2)
    );

    sb_t         co_sb;
    logic [16:0] co_u;
    assign co_sb = co_sb2[SB2W-1:17];
    assign co_u  = co_sb2[16:0];

    // Multiply stage.
    logic               m_valid_reg;
    sb_t                m_sb_reg;
    logic [16:0]        m_u_reg;
    logic signed [49:0] m_px_reg, m_pz_reg;
    logic signed [33:0] m_c_reg, m_s_reg;
    logic               m_rz_reg;
    logic [14:0]        r_sel;
    assign r_sel = co_sb.ring ? top_radius_reg : bottom_radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= co_valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_sb_reg <= co_sb;
            m_u_reg  <= co_u;
            m_px_reg <= co_cos * $signed({1'b0, r_sel});
            m_pz_reg <= co_sin * $signed({1'b0, r_sel});
            m_c_reg  <= co_cos;
            m_s_reg  <= co_sin;
            m_rz_reg <= r_sel == '0;
        end
    end

    function automatic logic signed [15:0] rnd_sat(input logic signed [49:0] v,
                                                   input int s,
                                                   input logic signed [49:0] lo,
                                                   input logic signed [49:0] hi);
        logic signed [49:0] mag, q, half;
        begin
            half = 50'sd1 <<< (s - 1);
            if (!v[49])
                q = (v + half) >>> s;
            else
            begin
                mag = -v;
                q = -((mag + half) >>> s);
            end
            if (q < lo)
                q = lo;
            else if (q > hi)
                q = hi;
            return q[15:0];
        end
    endfunction

    // Result stage: builds the first (and optional second) result.
    cmvg_pkg::cmvg_out_t r0_next, r1_next;
    logic                two_next;
    logic [9:0]          i10, n10;
    logic [15:0]         half_h;

    always_comb
    begin
        i10 = {1'b0, m_sb_reg.slice};
        n10 = {1'b0, m_sb_reg.n};
        half_h = {1'b0, cyl_height_reg[15:1]};
        r0_next = '0;
        r1_next = '0;
        two_next = 1'b0;
        if (m_sb_reg.err)
        begin
            r0_next.range_error = 1'b1;
            r0_next.last = 1'b1;
        end
        else if (m_sb_reg.mode == cmvg_pkg::MODE_VERTEX)
        begin
            r0_next.pos_x = rnd_sat(m_px_reg, 30, -50'sd32768, 50'sd32767);
            r0_next.pos_z = rnd_sat(m_pz_reg, 30, -50'sd32768, 50'sd32767);
            r0_next.pos_y = m_sb_reg.ring ? half_h : 16'(-half_h);
            if (!m_rz_reg)
            begin
                r0_next.normal_x = rnd_sat(50'(m_c_reg), 16, -50'sd16384, 50'sd16384);
                r0_next.normal_z = rnd_sat(50'(m_s_reg), 16, -50'sd16384, 50'sd16384);
            end
            r0_next.tex_u = m_u_reg;
            r0_next.tex_v = m_sb_reg.ring ? 17'd0 : 17'd65536;
            r0_next.last = 1'b1;
        end
        else
        begin
            two_next = 1'b1;
            r0_next.index_a = i10;
            r0_next.index_b = i10 + n10 + 10'd1;
            r0_next.index_c = i10 + n10 + 10'd2;
            r1_next.index_a = i10;
            r1_next.index_b = i10 + n10 + 10'd2;
            r1_next.index_c = i10 + 10'd1;
            r1_next.last = 1'b1;
        end
    end

    // Output register plus a pending second triangle. The pipe advances when
    // the output register can be reloaded and no second triangle waits.
    logic                out_valid_reg, pend_reg;
    cmvg_pkg::cmvg_out_t out_reg, pend_data_reg;
    logic                out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign en       = out_free && !pend_reg;
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else if (out_free)
        begin
            if (pend_reg)
            begin
                out_valid_reg <= 1'b1;
                pend_reg      <= 1'b0;
            end
            else
            begin
                out_valid_reg <= m_valid_reg;
                pend_reg      <= m_valid_reg && two_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (pend_reg)
                out_reg <= pend_data_reg;
            else
            begin
                out_reg       <= r0_next;
                pend_data_reg <= r1_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A waiting second triangle always sits behind a shown first one.
    assert property (@(posedge clk) disable iff (!rst_n) pend_reg |-> out_valid_reg)
        else $error("second triangle pending without a shown result");
    // While a second triangle waits, no input item is accepted.
    assert property (@(posedge clk) disable iff (!rst_n) pend_reg |-> in_stall)
        else $error("input accepted while a second triangle is pending");
    // A shown first triangle of a pair is never marked last.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && !out_data.range_error) |-> !out_data.last)
        else $error("first triangle marked last");
endmodule
`default_nettype wire

[hw/rtl/cmvg_divider.sv]
`default_nettype none
// Pipelined restoring divider: quotient = floor(i * 2^32 / n), one quotient bit
// per stage. The user must keep the slice index below or equal to n (unchecked)
// so the quotient fits in 33 bits. Sideband data travels alongside unchanged.
module cmvg_divider #(
    parameter int NW = 9,
    parameter int SBW = 8
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              en,
    input  wire              in_valid,
    input  wire [NW-1:0]     in_num,
    input  wire [NW-1:0]     in_den,
    input  wire [SBW-1:0]    in_sb,
    output logic             out_valid,
    output logic [32:0]      out_quot,
    output logic [SBW-1:0]   out_sb
);
    localparam int STEPS = 33;

    logic [STEPS:0]          vld_reg;
    logic [NW:0]             rem_reg  [STEPS+1];
    logic [32:0]             quot_reg [STEPS+1];
    logic [NW-1:0]           den_reg  [STEPS+1];
    logic [SBW-1:0]          sb_reg   [STEPS+1];

    always_comb
    begin
        rem_reg[0]  = {1'b0, in_num};
        quot_reg[0] = '0;
        den_reg[0]  = in_den;
        sb_reg[0]   = in_sb;
    end

    // Dividend is num * 2^32: the numerator itself gives the top remainder,
    // the 32 appended zero bits are shifted in one per stage. The first step
    // tests num >= den with no shift.
    genvar g;
    generate
        for (g = 0; g < STEPS; g++)
        begin : g_step
            logic [NW+1:0] trial;
            logic          ge;
            logic [NW:0]   rem_next;
            always_comb
            begin
                if (g == 0)
                    trial = {1'b0, rem_reg[g]};
                else
                    trial = {rem_reg[g], 1'b0};
                ge = trial >= {2'b0, den_reg[g]};
                rem_next = ge ? (NW+1)'(trial - {2'b0, den_reg[g]})
                              : (NW+1)'(trial);
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[g+1] <= 1'b0;
                else if (en)
                    vld_reg[g+1] <= (g == 0) ? in_valid : vld_reg[g];
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g+1]  <= rem_next;
                    quot_reg[g+1] <= {quot_reg[g][31:0], ge};
                    den_reg[g+1]  <= den_reg[g];
                    sb_reg[g+1]   <= sb_reg[g];
                end
            end
        end
    endgenerate

    assign vld_reg[0] = in_valid;
    assign out_valid  = vld_reg[STEPS];
    assign out_quot   = quot_reg[STEPS];
    assign out_sb     = sb_reg[STEPS];
endmodule
`default_nettype wire

[hw/rtl/cmvg_cordic.sv]
`default_nettype none
// Pipelined rotation-mode CORDIC, one micro-rotation per register stage.
module cmvg_cordic #(
    parameter int STAGES = 16,
    parameter int SBW = 8
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                en,
    input  wire                in_valid,
    input  wire [31:0]         in_phase,
    input  wire [SBW-1:0]      in_sb,
    output logic               out_valid,
    output logic signed [33:0] out_cos,
    output logic signed [33:0] out_sin,
    output logic [SBW-1:0]     out_sb
);
    logic                vld [STAGES+1];
    logic signed [33:0]  xr  [STAGES+1];
    logic signed [33:0]  yr  [STAGES+1];
    logic signed [33:0]  zr  [STAGES+1];
    logic [1:0]          qr  [STAGES+1];
    logic [SBW-1:0]      sbr [STAGES+1];

    always_comb
    begin
        vld[0] = in_valid;
        xr[0]  = cmvg_pkg::CORDIC_ONE;
        yr[0]  = '0;
        zr[0]  = {4'b0, in_phase[29:0]};
        qr[0]  = in_phase[31:30];
        sbr[0] = in_sb;
    end

    genvar k;
    generate
        for (k = 0; k < STAGES; k++)
        begin : g_rot
            localparam logic signed [33:0] ATAN = cmvg_pkg::atan_entry(k);
            logic signed [33:0] dx, dy;
            always_comb
            begin
                dx = yr[k] >>> k;
                dy = xr[k] >>> k;
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld[k+1] <= 1'b0;
                else if (en)
                    vld[k+1] <= vld[k];
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!zr[k][33])
                    begin
                        xr[k+1] <= xr[k] - dx;
                        yr[k+1] <= yr[k] + dy;
                        zr[k+1] <= zr[k] - ATAN;
                    end
                    else
                    begin
                        xr[k+1] <= xr[k] + dx;
                        yr[k+1] <= yr[k] - dy;
                        zr[k+1] <= zr[k] + ATAN;
                    end
                    qr[k+1]  <= qr[k];
                    sbr[k+1] <= sbr[k];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= vld[STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unique case (qr[STAGES])
                2'd0:
                begin
                    out_cos <= xr[STAGES];
                    out_sin <= yr[STAGES];
                end
                2'd1:
                begin
                    out_cos <= -yr[STAGES];
                    out_sin <= xr[STAGES];
                end
                2'd2:
                begin
                    out_cos <= -xr[STAGES];
                    out_sin <= -yr[STAGES];
                end
                default:
                begin
                    out_cos <= yr[STAGES];
                    out_sin <= -xr[STAGES];
                end
            endcase
            out_sb <= sbr[STAGES];
        end
    end
endmodule
`default_nettype wire
